### src/bmp_pkg.sv
package bmp_pkg;

  localparam int N_BITS_DEF = 16;
  localparam int P_BITS_DEF = 31;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACT,
    ST_FACT_W,
    ST_POW_INIT,
    ST_PM,
    ST_PM_W,
    ST_PS,
    ST_PS_W,
    ST_RES,
    ST_RES_W
  } bmp_state_t;

endpackage

### src/binomial_mod_prime_core.sv
// Channel  | Ports                     | Handshake
// ---------+---------------------------+------------------------------------
// input    | n_total, r_chosen         | taken when start & !busy
// output   | result                    | one-cycle strobe on done
// config   | cfg_wdata                 | written when cfg_we
//
// One bit-serial modular multiplier does all the work: n products for the
// factorials, then per inverse up to 2*P_BITS products, then two final
// products. r zero, r above n, or a modulus below two raise done in the
// cycle after start. Reset sets the modulus to its default and idles the
// block. Results cannot be stalled.
module binomial_mod_prime_core
  import bmp_pkg::*;
#(
  parameter int N_BITS = N_BITS_DEF,
  parameter int P_BITS = P_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [N_BITS-1:0] n_total,
  input  logic [N_BITS-1:0] r_chosen,
  output logic              done,
  output logic [P_BITS-1:0] result,
  input  logic              cfg_we,
  input  logic [P_BITS-1:0] cfg_wdata
);

  localparam int CW = (P_BITS > 1) ? $clog2(P_BITS) : 1;

  bmp_state_t state, state_next;

  logic [P_BITS-1:0] modulus;
  logic [N_BITS-1:0] n_r;
  logic [N_BITS-1:0] r_r;
  logic [N_BITS-1:0] nr_r;
  logic [N_BITS-1:0] i_cnt;
  logic [P_BITS-1:0] i_mod;
  logic [P_BITS-1:0] i_mod_inc;
  logic [P_BITS-1:0] fac;
  logic [P_BITS-1:0] fac_r;
  logic [P_BITS-1:0] fac_nr;
  logic [P_BITS-1:0] base;
  logic [P_BITS-1:0] pacc;
  logic [P_BITS-1:0] exp_sh;
  logic [CW-1:0]     ecnt;
  logic              sel;
  logic              trivial;

  logic              mul_start;
  logic [P_BITS-1:0] mul_a;
  logic [P_BITS-1:0] mul_b;
  logic              mul_done;
  logic [P_BITS-1:0] mul_prod;

  bmp_modmul #(.P_BITS(P_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (modulus),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign busy      = (state != ST_IDLE);
  assign trivial   = (r_chosen == '0) || (r_chosen > n_total) || (modulus < P_BITS'(2));
  assign i_mod_inc = (i_mod + 1'b1 == modulus) ? '0 : i_mod + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && !trivial) state_next = ST_FACT;
      end
      ST_FACT:   state_next = ST_FACT_W;
      ST_FACT_W: begin
        if (mul_done) state_next = (i_cnt == n_r) ? ST_POW_INIT : ST_FACT;
      end
      ST_POW_INIT: state_next = ST_PM;
      ST_PM:       state_next = exp_sh[0] ? ST_PM_W : ST_PS;
      ST_PM_W: begin
        if (mul_done) state_next = ST_PS;
      end
      ST_PS:       state_next = ST_PS_W;
      ST_PS_W: begin
        if (mul_done) state_next = (ecnt == CW'(P_BITS - 1)) ? ST_RES : ST_PM;
      end
      ST_RES:      state_next = ST_RES_W;
      ST_RES_W: begin
        if (mul_done) state_next = sel ? ST_IDLE : ST_POW_INIT;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = fac;
    mul_b     = i_mod;
    case (state)
      ST_FACT: begin
        mul_start = 1'b1;
      end
      ST_PM: begin
        mul_start = exp_sh[0];
        mul_a     = pacc;
        mul_b     = base;
      end
      ST_PS: begin
        mul_start = 1'b1;
        mul_a     = base;
        mul_b     = base;
      end
      ST_RES: begin
        mul_start = 1'b1;
        mul_a     = fac;
        mul_b     = pacc;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      modulus <= P_BITS'(MODULUS_RESET);
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) modulus <= cfg_wdata;
      if (state == ST_IDLE && start && trivial) done <= 1'b1;
      if (state == ST_RES_W && mul_done && sel) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          result <= (r_chosen == '0) ? P_BITS'(1) : '0;
          n_r    <= n_total;
          r_r    <= r_chosen;
          nr_r   <= n_total - r_chosen;
          i_cnt  <= N_BITS'(1);
          i_mod  <= P_BITS'(1);
          fac    <= P_BITS'(1);
          fac_r  <= P_BITS'(1);
          fac_nr <= P_BITS'(1);
          sel    <= 1'b0;
        end
      end
      ST_FACT_W: begin
        if (mul_done) begin
          fac   <= mul_prod;
          if (i_cnt == r_r)  fac_r  <= mul_prod;
          if (i_cnt == nr_r) fac_nr <= mul_prod;
          i_cnt <= i_cnt + 1'b1;
          i_mod <= i_mod_inc;
        end
      end
      ST_POW_INIT: begin
        base   <= sel ? fac_nr : fac_r;
        pacc   <= P_BITS'(1);
        exp_sh <= modulus - P_BITS'(2);
        ecnt   <= '0;
      end
      ST_PM_W: begin
        if (mul_done) pacc <= mul_prod;
      end
      ST_PS_W: begin
        if (mul_done) begin
          base   <= mul_prod;
          exp_sh <= exp_sh >> 1;
          ecnt   <= ecnt + 1'b1;
        end
      end
      ST_RES_W: begin
        if (mul_done) begin
          fac    <= mul_prod;
          result <= mul_prod;
          sel    <= 1'b1;
        end
      end
      default: begin
        sel <= sel;
      end
    endcase
  end

endmodule

### src/bmp_modmul.sv
module bmp_modmul
  import bmp_pkg::*;
#(
  parameter int P_BITS = P_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [P_BITS-1:0] a,
  input  logic [P_BITS-1:0] b,
  input  logic [P_BITS-1:0] p,
  output logic              done,
  output logic [P_BITS-1:0] prod
);

  localparam int CW = (P_BITS > 1) ? $clog2(P_BITS) : 1;

  logic              active;
  logic [CW-1:0]     cnt;
  logic [P_BITS-1:0] acc;
  logic [P_BITS-1:0] acc_next;
  logic [P_BITS-1:0] a_r;
  logic [P_BITS-1:0] b_sh;
  logic [P_BITS:0]   dbl;
  logic [P_BITS:0]   dbl_red;
  logic [P_BITS:0]   sum;
  logic [P_BITS:0]   p_ext;

  // acc = (2*acc + bit*a) mod p, MSB of b first
  always_comb begin
    p_ext   = {1'b0, p};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
    sum     = dbl_red + (b_sh[P_BITS-1] ? {1'b0, a_r} : '0);
    if (sum >= p_ext) begin
      sum = sum - p_ext;
    end
    acc_next = sum[P_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(P_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_r  <= a;
      b_sh <= b;
    end else if (active) begin
      acc  <= acc_next;
      b_sh <= {b_sh[P_BITS-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule
